>>> hw/rtl/mva_pkg.sv
package mva_pkg;

  localparam int VOICES_DEF = 8;
  localparam int CH_COUNT   = 16;

  localparam logic [4:0] MASTER_RST = 5'd0;
  localparam logic [3:0] ACTIVE_RST = 4'd8;
  localparam logic [7:0] DEPTH_RST  = 8'd32;
  localparam logic [14:0] TIMBRE_RST = 15'd8192;
  localparam logic [14:0] Q14_ONE    = 15'd16384;

  typedef enum logic [2:0] {
    OP_NOTE_ON  = 3'd0,
    OP_NOTE_OFF = 3'd1,
    OP_BEND     = 3'd2,
    OP_PRESSURE = 3'd3,
    OP_TIMBRE   = 3'd4,
    OP_ALL_OFF  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ACT_PITCH   = 3'd0,
    ACT_LEVEL   = 3'd1,
    ACT_CUTOFF  = 3'd2,
    ACT_GATE_ON = 3'd3,
    ACT_GATE_OFF = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    REG_MASTER = 2'd0,
    REG_ACTIVE = 2'd1,
    REG_DEPTH  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_CHOOSE,
    ST_NEXT,
    ST_EMIT
  } state_t;

  // classified event word passed from front to back
  typedef struct packed {
    op_t                op;
    logic [4:0]         ch;
    logic [6:0]         note;
    logic [6:0]         vel;
    logic signed [15:0] amt;
    logic [14:0]        q;
  } cmd_t;

endpackage

>>> hw/rtl/mva_cmd_fifo.sv
module mva_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mva_pkg::cmd_t wdata,
  input  logic          pop,
  output mva_pkg::cmd_t rdata,
  output logic          empty,
  output logic          full
);

  mva_pkg::cmd_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign rdata = mem[rp];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wdata;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> hw/rtl/mva_front.sv
module mva_front (
  input  logic               start,
  input  logic               full,
  input  logic [2:0]         operation,
  input  logic [4:0]         channel,
  input  logic [6:0]         note,
  input  logic [6:0]         velocity,
  input  logic signed [15:0] amount,
  input  logic [4:0]         master_channel,
  input  logic [3:0]         active_voices,
  output logic               busy,
  output logic               push,
  output mva_pkg::cmd_t      cmd
);

  logic ch_ok;
  logic keep;

  assign busy  = full;
  assign ch_ok = (channel != 5'd0) && (channel <= 5'd16);

  always_comb begin
    case (operation)
      mva_pkg::OP_NOTE_ON:
        keep = ch_ok && (active_voices != 4'd0)
               && !((master_channel != 5'd0) && (channel == master_channel));
      mva_pkg::OP_TIMBRE:   keep = ch_ok;
      mva_pkg::OP_NOTE_OFF,
      mva_pkg::OP_BEND,
      mva_pkg::OP_PRESSURE,
      mva_pkg::OP_ALL_OFF:  keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  always_comb begin
    cmd.op   = mva_pkg::op_t'(operation);
    cmd.ch   = channel;
    cmd.note = note;
    cmd.vel  = velocity;
    cmd.amt  = amount;
    // Q14 clamp to 0..1.0
    if (amount[15]) cmd.q = 15'd0;
    else if (amount > 16'sd16384) cmd.q = mva_pkg::Q14_ONE;
    else cmd.q = amount[14:0];
  end

  assign push = start && !full && keep;

endmodule

>>> hw/rtl/mva_back.sv
module mva_back #(
  parameter int VOICES = mva_pkg::VOICES_DEF,
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1,
  localparam int CW  = $clog2(VOICES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  mva_pkg::cmd_t      head,
  output logic               pop,
  input  logic [3:0]         active_voices,
  input  logic [7:0]         cutoff_depth,
  output logic               valid,
  output logic [VIW-1:0]     voice_index,
  output logic [2:0]         action,
  output logic signed [16:0] pitch,
  output logic [21:0]        level,
  output logic signed [22:0] cutoff_offset,
  output logic               last
);

  mva_pkg::state_t state, state_next;
  mva_pkg::cmd_t   cmd;

  logic [4:0]  v_ch     [VOICES];
  logic [6:0]  v_note   [VOICES];
  logic        v_held   [VOICES];
  logic [31:0] v_stamp  [VOICES];
  logic signed [15:0] v_bend [VOICES];
  logic [6:0]  v_vel    [VOICES];
  logic [14:0] v_press  [VOICES];
  logic [14:0] v_timbre [VOICES];
  logic [14:0] ch_timbre [mva_pkg::CH_COUNT];
  logic [31:0] age;

  logic [VOICES-1:0] mask, mask_load, cur_bit;
  logic [VIW-1:0]    cnt, cur, bf, ba, pe, rd;
  logic [31:0]       bf_stamp, ba_stamp;
  logic              found_free, last_flag;
  logic [CW-1:0]     nv;
  logic [VIW-1:0]    n_last;
  logic [3:0]        cti;
  logic [3:0]        head_cti;

  assign nv = ({1'b0, active_voices} > 5'(VOICES)) ? CW'(VOICES) : CW'(active_voices);
  assign n_last   = VIW'(nv - CW'(1));
  assign cti      = 4'(cmd.ch[3:0] - 4'd1);
  assign head_cti = 4'(head.ch[3:0] - 4'd1);
  assign pop      = (state == mva_pkg::ST_IDLE) && !empty;
  assign rd       = (state == mva_pkg::ST_PICK) ? cnt : cur;

  // voices touched by the head event
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      if (head.op == mva_pkg::OP_ALL_OFF)
        mask_load[i] = (CW'(i) < nv) && ((head.ch == 5'd0) || (v_ch[i] == head.ch));
      else if (head.op == mva_pkg::OP_NOTE_OFF)
        mask_load[i] = (CW'(i) < nv) && v_held[i] && (v_ch[i] == head.ch)
                       && (v_note[i] == head.note);
      else
        mask_load[i] = (CW'(i) < nv) && v_held[i] && (v_ch[i] == head.ch);
    end
  end

  // lowest set bit
  always_comb begin
    pe = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (mask[i]) pe = VIW'(i);
    end
    cur_bit = '0;
    cur_bit[pe] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= mva_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      mva_pkg::ST_IDLE: begin
        if (!empty) begin
          state_next = (head.op == mva_pkg::OP_NOTE_ON) ? mva_pkg::ST_PICK
                                                         : mva_pkg::ST_NEXT;
        end
      end
      mva_pkg::ST_PICK:   if (cnt == n_last) state_next = mva_pkg::ST_CHOOSE;
      mva_pkg::ST_CHOOSE: state_next = mva_pkg::ST_NEXT;
      mva_pkg::ST_NEXT:   state_next = (mask == '0) ? mva_pkg::ST_IDLE : mva_pkg::ST_EMIT;
      mva_pkg::ST_EMIT:   state_next = last_flag ? mva_pkg::ST_IDLE : mva_pkg::ST_NEXT;
      default:            state_next = mva_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
      for (int i = 0; i < VOICES; i++) begin
        v_ch[i]     <= '0;
        v_note[i]   <= '0;
        v_held[i]   <= 1'b0;
        v_stamp[i]  <= '0;
        v_bend[i]   <= '0;
        v_vel[i]    <= '0;
        v_press[i]  <= '0;
        v_timbre[i] <= '0;
      end
      for (int c = 0; c < mva_pkg::CH_COUNT; c++) ch_timbre[c] <= mva_pkg::TIMBRE_RST;
    end else begin
      valid <= (state == mva_pkg::ST_EMIT);
      case (state)
        mva_pkg::ST_IDLE: begin
          if (!empty) begin
            cmd        <= head;
            mask       <= mask_load;
            cnt        <= '0;
            found_free <= 1'b0;
            if (head.op == mva_pkg::OP_TIMBRE) ch_timbre[head_cti] <= head.q;
          end
        end
        mva_pkg::ST_PICK: begin
          // oldest released voice, and oldest overall as fallback
          if (!v_held[rd] && (!found_free || v_stamp[rd] < bf_stamp)) begin
            bf         <= rd;
            bf_stamp   <= v_stamp[rd];
            found_free <= 1'b1;
          end
          if (cnt == '0 || v_stamp[rd] < ba_stamp) begin
            ba       <= rd;
            ba_stamp <= v_stamp[rd];
          end
          cnt <= cnt + VIW'(1);
        end
        mva_pkg::ST_CHOOSE: begin
          mask <= VOICES'(1) << (found_free ? bf : ba);
        end
        mva_pkg::ST_NEXT: begin
          if (mask != '0) begin
            cur <= pe;
            if (cmd.op == mva_pkg::OP_NOTE_OFF || cmd.op == mva_pkg::OP_NOTE_ON) begin
              mask      <= '0;
              last_flag <= 1'b1;
            end else begin
              mask      <= mask & ~cur_bit;
              last_flag <= ((mask & ~cur_bit) == '0);
            end
            case (cmd.op)
              mva_pkg::OP_NOTE_ON: begin
                age           <= age + 32'd1;
                v_ch[pe]      <= cmd.ch;
                v_note[pe]    <= cmd.note;
                v_held[pe]    <= 1'b1;
                v_stamp[pe]   <= age + 32'd1;
                v_bend[pe]    <= '0;
                v_vel[pe]     <= cmd.vel;
                v_timbre[pe]  <= ch_timbre[cti];
                v_press[pe]   <= '0;
              end
              mva_pkg::OP_NOTE_OFF,
              mva_pkg::OP_ALL_OFF:  v_held[pe]   <= 1'b0;
              mva_pkg::OP_BEND:     v_bend[pe]   <= cmd.amt;
              mva_pkg::OP_PRESSURE: v_press[pe]  <= cmd.q;
              mva_pkg::OP_TIMBRE:   v_timbre[pe] <= cmd.q;
              default: ;
            endcase
          end
        end
        mva_pkg::ST_EMIT: begin
          last          <= last_flag;
          voice_index   <= cur;
          pitch         <= 17'($signed({1'b0, v_note[rd], 8'd0}) + 18'(v_bend[rd]));
          level         <= 22'(v_vel[rd]) * (22'(v_press[rd]) + 22'd16384);
          cutoff_offset <= 23'($signed({1'b0, v_timbre[rd], 1'b0} - 17'sd16384))
                           * 23'($signed({1'b0, cutoff_depth}));
          case (cmd.op)
            mva_pkg::OP_NOTE_ON:  action <= mva_pkg::ACT_GATE_ON;
            mva_pkg::OP_BEND:     action <= mva_pkg::ACT_PITCH;
            mva_pkg::OP_PRESSURE: action <= mva_pkg::ACT_LEVEL;
            mva_pkg::OP_TIMBRE:   action <= mva_pkg::ACT_CUTOFF;
            default:              action <= mva_pkg::ACT_GATE_OFF;
          endcase
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/mpe_voice_allocator.sv
// channel | direction | handshake          | word
// event   | in        | start / busy       | operation, channel, note, velocity, amount
// config  | in        | cfg_we             | cfg_index, cfg_data
// update  | out       | valid (one cycle)  | voice_index, action, pitch, level,
//         |           |                    | cutoff_offset, last
//
// An event word is taken when start is high and busy low; busy only rises
// when the two-entry event queue is full. The back end runs one event at a
// time: it pops the word from idle; note-on then scans one voice a cycle over
// the voices in use and then chooses one in a choose state. Each update
// passes a voice write state and the output register; an event with no
// update goes from the write state straight back to idle.
// Synchronous active-high reset; no clearing pass. Updates cannot be held off.
module mpe_voice_allocator #(
  parameter int VOICES = mva_pkg::VOICES_DEF,
  localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic [4:0]         channel,
  input  logic [6:0]         note,
  input  logic [6:0]         velocity,
  input  logic signed [15:0] amount,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               valid,
  output logic [VIW-1:0]     voice_index,
  output logic [2:0]         action,
  output logic signed [16:0] pitch,
  output logic [21:0]        level,
  output logic signed [22:0] cutoff_offset,
  output logic               last
);

  logic [4:0] master_channel;
  logic [3:0] active_voices;
  logic [7:0] cutoff_depth;

  mva_pkg::cmd_t f_cmd, q_head;
  logic push, pop, empty, full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      master_channel <= mva_pkg::MASTER_RST;
      active_voices  <= mva_pkg::ACTIVE_RST;
      cutoff_depth   <= mva_pkg::DEPTH_RST;
    end else if (cfg_we) begin
      case (mva_pkg::reg_idx_t'(cfg_index))
        mva_pkg::REG_MASTER: master_channel <= cfg_data[4:0];
        mva_pkg::REG_ACTIVE: active_voices  <= cfg_data[3:0];
        mva_pkg::REG_DEPTH:  cutoff_depth   <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept, drop ignored events, clamp Q14
  mva_front u_front (
    .start          (start),
    .full           (full),
    .operation      (operation),
    .channel        (channel),
    .note           (note),
    .velocity       (velocity),
    .amount         (amount),
    .master_channel (master_channel),
    .active_voices  (active_voices),
    .busy           (busy),
    .push           (push),
    .cmd            (f_cmd)
  );

  mva_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_cmd),
    .pop   (pop),
    .rdata (q_head),
    .empty (empty),
    .full  (full)
  );

  // back: voice state, age scan and update sequencer
  mva_back #(.VOICES(VOICES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (q_head),
    .pop           (pop),
    .active_voices (active_voices),
    .cutoff_depth  (cutoff_depth),
    .valid         (valid),
    .voice_index   (voice_index),
    .action        (action),
    .pitch         (pitch),
    .level         (level),
    .cutoff_offset (cutoff_offset),
    .last          (last)
  );

endmodule
